/* design/indexed_sequence_buffer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Indexed sequence buffer assertion macros
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_BUFFER_UNIT_MACROS_SVH
`define INDEXED_SEQUENCE_BUFFER_UNIT_MACROS_SVH

// Checked only outside reset.
`define ISBU_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("isbu check failed");

// Checked at every edge, reset included.
`define ISBU_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("isbu check failed");

`endif

/* design/isbu_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed sequence buffer package
// Operation and status codes and default sizing.
// ----------------------------------------------------------------------------
`default_nettype none
package isbu_pkg;
  localparam int CAPACITY_DEFAULT = 64;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_FRONT  = 3'd1;
  localparam logic [2:0] OP_APPEND = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
endpackage
`default_nettype wire

/* design/indexed_sequence_buffer_unit.sv */
// ----------------------------------------------------------------------------
// Indexed sequence buffer unit
// Ordered list of signed 32-bit values held in a RAM, edited by position.
// ----------------------------------------------------------------------------
// One request word in, one result word out. An insert at index p moves the
// length-p elements from p upward and a delete at index p moves the
// length-p-1 elements above p, each element passing once through the
// single RAM read port and then the write port. Refused or invalid
// requests skip the RAM. A new request is taken once the previous
// result has been loaded into the output register.
`default_nettype none
module indexed_sequence_buffer_unit #(
  parameter int CAPACITY = isbu_pkg::CAPACITY_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               request_valid,
  output logic                    request_stall,
  input  wire logic [2:0]         operation,
  input  wire logic [7:0]         position,
  input  wire logic signed [31:0] item_value,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [31:0]      read_value,
  output logic [1:0]              status,
  output logic [6:0]              length
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW : 8;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SHIFT_RD, S_SHIFT_WR, S_FIN} state_t;

  state_t         state;
  logic [CW-1:0]  count, cur, pos_q;
  logic           del_q;
  logic [31:0]    val_q, res_value;
  logic [1:0]     res_status;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]    ram_wdata, ram_rdata;

  logic [PW-1:0]  pos_w, cnt_w;
  logic           full;
  logic           more;
  logic           take;

  assign pos_w = PW'(position);
  assign cnt_w = PW'(count);
  assign full  = (count == CW'(CAPACITY));
  assign take  = request_valid && !request_stall;
  assign request_stall = (state != S_IDLE);

  // Whether another element still has to move.
  assign more = del_q ? ((cur + CW'(1)) < count) : (cur > pos_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = del_q ? AW'(cur + CW'(1)) : AW'(cur - CW'(1));
    case (state)
      S_IDLE: begin
        ram_raddr = AW'(position);
      end
      S_SHIFT_RD: begin
        if (!more && !del_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AW-1:0];
          ram_wdata = val_q;
        end
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  isbu_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      // In S_FIN the output register is reloaded instead.
      if (result_valid && !result_stall && state != S_FIN) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            res_value  <= 32'hFFFF_FFFF;
            res_status <= isbu_pkg::ST_DONE;
            val_q      <= item_value;
            del_q      <= 1'b0;
            state      <= S_FIN;
            case (operation)
              isbu_pkg::OP_READ: begin
                if (pos_w < cnt_w) state <= S_READ;
                else res_status <= isbu_pkg::ST_INVALID;
              end
              isbu_pkg::OP_FRONT: begin
                if (full) res_status <= isbu_pkg::ST_FULL;
                else begin
                  cur   <= count;
                  pos_q <= '0;
                  state <= S_SHIFT_RD;
                end
              end
              isbu_pkg::OP_APPEND: begin
                if (full) res_status <= isbu_pkg::ST_FULL;
                else begin
                  cur   <= count;
                  pos_q <= count;
                  state <= S_SHIFT_RD;
                end
              end
              isbu_pkg::OP_INSERT: begin
                if (pos_w > cnt_w) res_status <= isbu_pkg::ST_INVALID;
                else if (full) res_status <= isbu_pkg::ST_FULL;
                else begin
                  cur   <= count;
                  pos_q <= CW'(pos_w);
                  state <= S_SHIFT_RD;
                end
              end
              isbu_pkg::OP_DELETE: begin
                if (pos_w < cnt_w) begin
                  cur   <= CW'(pos_w);
                  del_q <= 1'b1;
                  state <= S_SHIFT_RD;
                end else begin
                  res_status <= isbu_pkg::ST_INVALID;
                end
              end
              default: begin
                res_status <= isbu_pkg::ST_INVALID;
              end
            endcase
          end
        end
        S_READ: begin
          res_value <= ram_rdata;
          state     <= S_FIN;
        end
        S_SHIFT_RD: begin
          if (more) begin
            state <= S_SHIFT_WR;
          end else begin
            count <= del_q ? (count - CW'(1)) : (count + CW'(1));
            state <= S_FIN;
          end
        end
        S_SHIFT_WR: begin
          cur   <= del_q ? (cur + CW'(1)) : (cur - CW'(1));
          state <= S_SHIFT_RD;
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            read_value   <= res_value;
            status       <= res_status;
            length       <= 7'(count);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/isbu_ram.sv */
// ----------------------------------------------------------------------------
// Indexed sequence buffer element RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module isbu_ram #(
  parameter int DEPTH = isbu_pkg::CAPACITY_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/isbu_checker.sv */
// ----------------------------------------------------------------------------
// Indexed sequence buffer port checker
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_sequence_buffer_unit_macros.svh"
module isbu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [31:0] read_value,
  input wire logic [1:0]  status
);
  `ISBU_CHECK(a_result_held, result_valid && result_stall |=> result_valid)
  `ISBU_CHECK(a_fail_value, result_valid && status != isbu_pkg::ST_DONE |-> read_value == 32'hFFFF_FFFF)
  `ISBU_CHECK(a_status_code, result_valid |-> status != 2'd3)
  `ISBU_CHECK_ALWAYS(a_reset_quiet, rst |=> !result_valid)
endmodule

bind indexed_sequence_buffer_unit isbu_checker u_isbu_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .read_value   (read_value),
  .status       (status)
);
`default_nettype wire
